// File: sv/fsc_pkg.sv
// Shared types and constants for the frustum shape cull block.
package fsc_pkg;

  localparam int DATA_W  = 32;
  localparam int RAD_W   = 31;
  localparam int IDX_W   = 3;
  localparam int ROWS    = 3;
  localparam int CORNERS = 8;

  localparam logic [2:0] ACT_LOAD_PLANE = 3'd0;
  localparam logic [2:0] ACT_LOAD_ROW   = 3'd1;
  localparam logic [2:0] ACT_POINT      = 3'd2;
  localparam logic [2:0] ACT_SPHERE     = 3'd3;
  localparam logic [2:0] ACT_BOX        = 3'd4;
  localparam logic [2:0] ACT_CAPSULE    = 3'd5;

  localparam logic [1:0] KIND_POINT   = 2'd0;
  localparam logic [1:0] KIND_SPHERE  = 2'd1;
  localparam logic [1:0] KIND_BOX     = 2'd2;
  localparam logic [1:0] KIND_CAPSULE = 2'd3;

  localparam logic [1:0] LAST_COMP   = 2'd2;
  localparam logic [2:0] LAST_CORNER = 3'(CORNERS - 1);

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_ACC,
    DP_BIAS,
    DP_ROT_MAC,
    DP_ROT_STORE,
    DP_CTR_CORNER,
    DP_DIFF,
    DP_MAC_LO,
    DP_MAC_HI
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] plane;
    logic [1:0] comp;
    logic [1:0] row;
    logic [2:0] corner;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_neg;
  } dp_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_RCLR,
    ST_RMAC,
    ST_RSTORE,
    ST_PBIAS,
    ST_DIFF,
    ST_MLO,
    ST_MHI,
    ST_CHK,
    ST_OUT
  } state_t;

endpackage

// File: sv/fsc_in_if.sv
// Input item channel of the frustum shape cull block.
interface fsc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [2:0]  slot;
  logic [31:0] center_x;
  logic [31:0] center_y;
  logic [31:0] center_z;
  logic [31:0] vec_b_x;
  logic [31:0] vec_b_y;
  logic [31:0] vec_b_z;
  logic [30:0] radius;

  modport source (output valid, action, slot, center_x, center_y, center_z,
                  vec_b_x, vec_b_y, vec_b_z, radius, input ready);
  modport sink (input valid, action, slot, center_x, center_y, center_z,
                vec_b_x, vec_b_y, vec_b_z, radius, output ready);
endinterface

// File: sv/fsc_out_if.sv
// Result channel of the frustum shape cull block.
interface fsc_out_if;
  logic       valid;
  logic       ready;
  logic       inside_res;
  logic [1:0] test_kind;

  modport source (output valid, inside_res, test_kind, input ready);
  modport sink (input valid, inside_res, test_kind, output ready);
endinterface

// File: sv/fsc_dp.sv
// Datapath: plane and orientation stores, shared multiplier and wide accumulator.
module fsc_dp #(
  parameter int NUM_PLANES    = 6,
  parameter int FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          action,
  input  logic [2:0]          slot,
  input  logic [31:0]         center_x,
  input  logic [31:0]         center_y,
  input  logic [31:0]         center_z,
  input  logic [31:0]         vec_b_x,
  input  logic [31:0]         vec_b_y,
  input  logic [31:0]         vec_b_z,
  input  logic [30:0]         radius,
  input  fsc_pkg::dp_cmd_t    cmd,
  output fsc_pkg::dp_stat_t   stat
);

  localparam int PW     = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int CORN_W = 66 - FRACTION_BITS;
  localparam int DIFF_W = CORN_W + 1;
  localparam int HI_W   = 33;
  localparam int LO_W   = DIFF_W - HI_W;
  localparam int ACC_W  = DIFF_W + 34;
  localparam int PROD_W = fsc_pkg::DATA_W + HI_W;

  logic signed [31:0] normal_r [NUM_PLANES][fsc_pkg::ROWS];
  logic signed [31:0] point_r  [NUM_PLANES][fsc_pkg::ROWS];
  logic signed [31:0] orient_r [fsc_pkg::ROWS][fsc_pkg::ROWS];

  logic signed [31:0]       ctr_r    [fsc_pkg::ROWS];
  logic signed [31:0]       half_r   [fsc_pkg::ROWS];
  logic signed [CORN_W-1:0] corner_r [fsc_pkg::ROWS];
  logic signed [ACC_W-1:0]  bias_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic signed [31:0]       in_ctr [fsc_pkg::ROWS];
  logic signed [31:0]       in_vb  [fsc_pkg::ROWS];
  logic signed [31:0]       half_nxt [fsc_pkg::ROWS];
  logic signed [31:0]       half_sel;
  logic signed [31:0]       off_c;
  logic signed [31:0]       mul_a;
  logic signed [HI_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_shift;
  logic [PW-1:0]            pidx;
  logic                     is_capsule;

  assign in_ctr[0] = $signed(center_x);
  assign in_ctr[1] = $signed(center_y);
  assign in_ctr[2] = $signed(center_z);
  assign in_vb[0]  = $signed(vec_b_x);
  assign in_vb[1]  = $signed(vec_b_y);
  assign in_vb[2]  = $signed(vec_b_z);

  assign pidx       = cmd.plane[PW-1:0];
  assign is_capsule = (action == fsc_pkg::ACT_CAPSULE);

  always_comb begin
    for (int c = 0; c < fsc_pkg::ROWS; c++) begin
      half_nxt[c] = in_vb[c] >>> 1;
    end
    if (is_capsule) begin
      half_nxt[0] = $signed(32'({1'b0, radius} >> 1));
      half_nxt[2] = $signed(32'({1'b0, radius} >> 1));
    end
  end

  assign half_sel = half_r[cmd.comp];
  assign off_c    = cmd.corner[cmd.comp] ? half_sel : -half_sel;

  always_comb begin
    mul_a = normal_r[pidx][cmd.comp];
    mul_b = $signed({{(HI_W-LO_W){1'b0}}, diff_r[LO_W-1:0]});
    case (cmd.op)
      fsc_pkg::DP_ROT_MAC: begin
        mul_a = orient_r[cmd.row][cmd.comp];
        mul_b = HI_W'(off_c);
      end
      fsc_pkg::DP_MAC_HI: begin
        mul_b = $signed(diff_r[DIFF_W-1:LO_W]);
      end
      default: begin
      end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign prod_ext  = ACC_W'(prod);
  assign acc_shift = acc_r >>> FRACTION_BITS;
  assign stat.acc_neg = acc_r[ACC_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          normal_r[k][c] <= '0;
          point_r[k][c]  <= '0;
        end
      end
      for (int r = 0; r < fsc_pkg::ROWS; r++) begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          orient_r[r][c] <= '0;
        end
      end
    end else if (cmd.op == fsc_pkg::DP_LOAD) begin
      if (action == fsc_pkg::ACT_LOAD_PLANE && {1'b0, slot} < 4'(NUM_PLANES)) begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          point_r[slot[PW-1:0]][c]  <= in_ctr[c];
          normal_r[slot[PW-1:0]][c] <= in_vb[c];
        end
      end
      if (action == fsc_pkg::ACT_LOAD_ROW && slot < 3'(fsc_pkg::ROWS)) begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          orient_r[slot[1:0]][c] <= in_ctr[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fsc_pkg::DP_LOAD: begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          ctr_r[c]  <= in_ctr[c];
          half_r[c] <= half_nxt[c];
        end
        bias_r <= (action == fsc_pkg::ACT_SPHERE) ?
                  (ACC_W'(radius) << FRACTION_BITS) : '0;
      end
      fsc_pkg::DP_CLR_ACC:   acc_r <= '0;
      fsc_pkg::DP_BIAS:      acc_r <= bias_r;
      fsc_pkg::DP_ROT_MAC:   acc_r <= acc_r + prod_ext;
      fsc_pkg::DP_MAC_LO:    acc_r <= acc_r + prod_ext;
      fsc_pkg::DP_MAC_HI:    acc_r <= acc_r + (prod_ext <<< LO_W);
      fsc_pkg::DP_ROT_STORE: begin
        corner_r[cmd.row] <= CORN_W'(acc_shift) + CORN_W'(ctr_r[cmd.row]);
      end
      fsc_pkg::DP_CTR_CORNER: begin
        for (int c = 0; c < fsc_pkg::ROWS; c++) begin
          corner_r[c] <= CORN_W'(ctr_r[c]);
        end
      end
      fsc_pkg::DP_DIFF: begin
        diff_r <= DIFF_W'(corner_r[cmd.comp]) - DIFF_W'(point_r[pidx][cmd.comp]);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/fsc_ctrl.sv
// Controller: sequences loads, corner rotation and plane tests, holds the result.
module fsc_ctrl #(
  parameter int NUM_PLANES = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [2:0]        in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              inside_res,
  output logic [1:0]        test_kind,
  output fsc_pkg::dp_cmd_t  cmd,
  input  fsc_pkg::dp_stat_t stat
);

  fsc_pkg::state_t state_r, state_nxt;
  logic [2:0] plane_r, plane_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] row_r, row_nxt;
  logic [2:0] corner_r, corner_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic       inside_r, inside_nxt;
  logic       is_test;

  assign is_test = (in_action >= fsc_pkg::ACT_POINT) && (in_action <= fsc_pkg::ACT_CAPSULE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fsc_pkg::ST_IDLE;
      plane_r  <= '0;
      comp_r   <= '0;
      row_r    <= '0;
      corner_r <= '0;
      kind_r   <= fsc_pkg::KIND_POINT;
      inside_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      plane_r  <= plane_nxt;
      comp_r   <= comp_nxt;
      row_r    <= row_nxt;
      corner_r <= corner_nxt;
      kind_r   <= kind_nxt;
      inside_r <= inside_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    plane_nxt  = plane_r;
    comp_nxt   = comp_r;
    row_nxt    = row_r;
    corner_nxt = corner_r;
    kind_nxt   = kind_r;
    inside_nxt = inside_r;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.op     = fsc_pkg::DP_NOP;
    cmd.plane  = plane_r;
    cmd.comp   = comp_r;
    cmd.row    = row_r;
    cmd.corner = corner_r;
    case (state_r)
      fsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = fsc_pkg::DP_LOAD;
          if (is_test) begin
            kind_nxt  = 2'(in_action - fsc_pkg::ACT_POINT);
            state_nxt = fsc_pkg::ST_START;
          end
        end
      end
      fsc_pkg::ST_START: begin
        plane_nxt  = '0;
        row_nxt    = '0;
        comp_nxt   = '0;
        corner_nxt = '0;
        if (kind_r[1]) begin
          state_nxt = fsc_pkg::ST_RCLR;
        end else begin
          cmd.op    = fsc_pkg::DP_CTR_CORNER;
          state_nxt = fsc_pkg::ST_PBIAS;
        end
      end
      fsc_pkg::ST_RCLR: begin
        cmd.op    = fsc_pkg::DP_CLR_ACC;
        comp_nxt  = '0;
        state_nxt = fsc_pkg::ST_RMAC;
      end
      fsc_pkg::ST_RMAC: begin
        cmd.op = fsc_pkg::DP_ROT_MAC;
        if (comp_r == fsc_pkg::LAST_COMP) begin
          state_nxt = fsc_pkg::ST_RSTORE;
        end else begin
          comp_nxt = comp_r + 2'd1;
        end
      end
      fsc_pkg::ST_RSTORE: begin
        cmd.op = fsc_pkg::DP_ROT_STORE;
        if (row_r == fsc_pkg::LAST_COMP) begin
          row_nxt   = '0;
          plane_nxt = '0;
          state_nxt = fsc_pkg::ST_PBIAS;
        end else begin
          row_nxt   = row_r + 2'd1;
          state_nxt = fsc_pkg::ST_RCLR;
        end
      end
      fsc_pkg::ST_PBIAS: begin
        cmd.op    = fsc_pkg::DP_BIAS;
        comp_nxt  = '0;
        state_nxt = fsc_pkg::ST_DIFF;
      end
      fsc_pkg::ST_DIFF: begin
        cmd.op    = fsc_pkg::DP_DIFF;
        state_nxt = fsc_pkg::ST_MLO;
      end
      fsc_pkg::ST_MLO: begin
        cmd.op    = fsc_pkg::DP_MAC_LO;
        state_nxt = fsc_pkg::ST_MHI;
      end
      fsc_pkg::ST_MHI: begin
        cmd.op = fsc_pkg::DP_MAC_HI;
        if (comp_r == fsc_pkg::LAST_COMP) begin
          state_nxt = fsc_pkg::ST_CHK;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = fsc_pkg::ST_DIFF;
        end
      end
      fsc_pkg::ST_CHK: begin
        if (stat.acc_neg) begin
          if (kind_r[1] && corner_r != fsc_pkg::LAST_CORNER) begin
            corner_nxt = corner_r + 3'd1;
            row_nxt    = '0;
            state_nxt  = fsc_pkg::ST_RCLR;
          end else begin
            inside_nxt = 1'b0;
            state_nxt  = fsc_pkg::ST_OUT;
          end
        end else if (plane_r == 3'(NUM_PLANES - 1)) begin
          inside_nxt = 1'b1;
          state_nxt  = fsc_pkg::ST_OUT;
        end else begin
          plane_nxt = plane_r + 3'd1;
          state_nxt = fsc_pkg::ST_PBIAS;
        end
      end
      fsc_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = fsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fsc_pkg::ST_IDLE;
      end
    endcase
  end

  assign inside_res = inside_r;
  assign test_kind  = kind_r;

endmodule

// File: sv/frustum_shape_cull.sv
// Top level of the frustum shape cull block.
// Load items (plane, orientation row) are taken while idle and return nothing. A point
// or sphere test checks the planes in turn before its result transfer; a box or
// capsule rotates each corner in turn and stops at the first corner that passes
// every plane. All multiplies go to one shared 32x33 multiplier: three per rotated
// corner row and two per plane component, each feeding one wide accumulator. One
// item is in work at a time; the result is held until its transfer completes.
module frustum_shape_cull #(
  parameter int NUM_PLANES    = 6,
  parameter int FRACTION_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  fsc_in_if.sink     in_ch,
  fsc_out_if.source  out_ch
);

  fsc_pkg::dp_cmd_t  cmd;
  fsc_pkg::dp_stat_t stat;

  fsc_ctrl #(
    .NUM_PLANES (NUM_PLANES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_action  (in_ch.action),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .inside_res (out_ch.inside_res),
    .test_kind  (out_ch.test_kind),
    .cmd        (cmd),
    .stat       (stat)
  );

  fsc_dp #(
    .NUM_PLANES    (NUM_PLANES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .action   (in_ch.action),
    .slot     (in_ch.slot),
    .center_x (in_ch.center_x),
    .center_y (in_ch.center_y),
    .center_z (in_ch.center_z),
    .vec_b_x  (in_ch.vec_b_x),
    .vec_b_y  (in_ch.vec_b_y),
    .vec_b_z  (in_ch.vec_b_z),
    .radius   (in_ch.radius),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// File: test/frustum_shape_cull_tb.sv
// Testbench for frustum_shape_cull: directed table plus random shapes checked by a predictor.
module frustum_shape_cull_tb;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;
  localparam int PLANES      = 6;
  localparam int FRAC        = 16;
  localparam int ONE         = 65536;
  localparam int RAND_ITEMS  = 1525;
  localparam int STALL_LIMIT = 8000;
  localparam int DRAIN       = 700;

  typedef longint vec3_t[3];

  typedef struct {
    logic [2:0]         action;
    logic [2:0]         slot;
    logic signed [31:0] cx, cy, cz;
    logic signed [31:0] bx, by, bz;
    logic [30:0]        rad;
    bit                 typed;
    bit                 want;
  } shape_item_t;

  typedef struct {
    logic       hit;
    logic [1:0] kind;
  } verdict_t;

  logic clk;
  logic rst_n;
  fsc_in_if  in_ch ();
  fsc_out_if out_ch ();

  frustum_shape_cull u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [31:0] plane_nrm [PLANES][3];
  logic signed [31:0] plane_pt  [PLANES][3];
  logic signed [31:0] orient    [3][3];
  verdict_t           pending_verdicts[$];
  int                 errors = 0;
  bit                 calm;
  int                 quiet_cycles;
  shape_item_t        directed_tbl[$];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic bit passes_planes(vec3_t p, logic signed [127:0] bias);
    logic signed [127:0] acc;
    logic signed [127:0] nrm;
    logic signed [127:0] diff;
    for (int k = 0; k < PLANES; k++) begin
      acc = bias;
      for (int c = 0; c < 3; c++) begin
        nrm  = plane_nrm[k][c];
        diff = p[c] - longint'(plane_pt[k][c]);
        acc  = acc + nrm * diff;
      end
      if (acc[127]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit box_visible(vec3_t ctr, vec3_t half);
    vec3_t  off;
    vec3_t  corner;
    longint sum;
    for (int i = 0; i < fsc_pkg::CORNERS; i++) begin
      for (int c = 0; c < 3; c++) off[c] = i[c] ? half[c] : -half[c];
      for (int r = 0; r < 3; r++) begin
        sum = 0;
        for (int c = 0; c < 3; c++) sum += longint'(orient[r][c]) * off[c];
        corner[r] = ctr[r] + (sum >>> FRAC);
      end
      if (passes_planes(corner, 0)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // update the shadow state; return 1 with a verdict when the item yields a result
  function automatic bit cull_predict(shape_item_t s, output verdict_t v);
    vec3_t ctr;
    vec3_t half;
    logic signed [127:0] bias;
    ctr[0] = longint'(s.cx);
    ctr[1] = longint'(s.cy);
    ctr[2] = longint'(s.cz);
    v.kind = 2'(s.action - fsc_pkg::ACT_POINT);
    case (s.action)
      fsc_pkg::ACT_LOAD_PLANE: begin
        if (s.slot < PLANES) begin
          plane_pt[s.slot]  = '{s.cx, s.cy, s.cz};
          plane_nrm[s.slot] = '{s.bx, s.by, s.bz};
        end
        return 1'b0;
      end
      fsc_pkg::ACT_LOAD_ROW: begin
        if (s.slot < fsc_pkg::ROWS) orient[s.slot] = '{s.cx, s.cy, s.cz};
        return 1'b0;
      end
      fsc_pkg::ACT_POINT: v.hit = passes_planes(ctr, 0);
      fsc_pkg::ACT_SPHERE: begin
        bias = 128'(s.rad) << FRAC;
        v.hit = passes_planes(ctr, bias);
      end
      fsc_pkg::ACT_BOX: begin
        half[0] = longint'(s.bx) >>> 1;
        half[1] = longint'(s.by) >>> 1;
        half[2] = longint'(s.bz) >>> 1;
        v.hit = box_visible(ctr, half);
      end
      fsc_pkg::ACT_CAPSULE: begin
        half[0] = longint'(s.rad >> 1);
        half[1] = longint'(s.by) >>> 1;
        half[2] = longint'(s.rad >> 1);
        v.hit = box_visible(ctr, half);
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic shape_item_t mk(logic [2:0] act, logic [2:0] slot,
                                     int cx, int cy, int cz, int bx, int by, int bz,
                                     logic [30:0] rad, bit typed = 0, bit want = 0);
    shape_item_t s;
    s = '{act, slot, cx, cy, cz, bx, by, bz, rad, typed, want};
    return s;
  endfunction

  function automatic int small_val(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  function automatic shape_item_t random_item();
    shape_item_t s;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      s = mk(fsc_pkg::ACT_LOAD_PLANE, 3'($urandom_range(0, 7)), small_val(1 << 19),
             small_val(1 << 19), small_val(1 << 19), small_val(2 * ONE),
             small_val(2 * ONE), small_val(2 * ONE), 0);
    end else if (pick < 12) begin
      s = mk(fsc_pkg::ACT_LOAD_ROW, 3'($urandom_range(0, 3)), small_val(2 * ONE),
             small_val(2 * ONE), small_val(2 * ONE), 0, 0, 0, 0);
    end else if (pick < 16) begin
      s = mk(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, 31'($urandom));
    end else begin
      s = mk(3'($urandom_range(fsc_pkg::ACT_POINT, fsc_pkg::ACT_CAPSULE)),
             3'($urandom_range(0, 7)),
             small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
             small_val(1 << 19), small_val(1 << 19), small_val(1 << 19),
             31'($urandom_range(0, 1 << 18)));
    end
    return s;
  endfunction

  task automatic send_item(shape_item_t s);
    verdict_t v;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= s.action;
    in_ch.slot     <= s.slot;
    in_ch.center_x <= s.cx;
    in_ch.center_y <= s.cy;
    in_ch.center_z <= s.cz;
    in_ch.vec_b_x  <= s.bx;
    in_ch.vec_b_y  <= s.by;
    in_ch.vec_b_z  <= s.bz;
    in_ch.radius   <= s.rad;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cull_predict(s, v)) begin
      if (s.typed) v.hit = s.want;
      pending_verdicts.insert(pending_verdicts.size(), v);
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= (calm || !rst_n) ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    verdict_t exp_v;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result transfer: inside_res=%0d test_kind=%0d",
               out_ch.inside_res, out_ch.test_kind);
        errors++;
      end else begin
        exp_v = pending_verdicts.pop_front();
        if (out_ch.inside_res !== exp_v.hit) begin
          $error("inside_res expected %0d actual %0d", exp_v.hit, out_ch.inside_res);
          errors++;
        end
        if (out_ch.test_kind !== exp_v.kind) begin
          $error("test_kind expected %0d actual %0d", exp_v.kind, out_ch.test_kind);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL frustum_shape_cull");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    calm = 1'b0;
    for (int k = 0; k < PLANES; k++) begin
      plane_nrm[k] = '{0, 0, 0};
      plane_pt[k]  = '{0, 0, 0};
    end
    for (int r = 0; r < 3; r++) orient[r] = '{0, 0, 0};
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.action   <= '0;
    in_ch.slot     <= '0;
    in_ch.center_x <= '0;
    in_ch.center_y <= '0;
    in_ch.center_z <= '0;
    in_ch.vec_b_x  <= '0;
    in_ch.vec_b_y  <= '0;
    in_ch.vec_b_z  <= '0;
    in_ch.radius   <= '0;

    directed_tbl = '{
      mk(fsc_pkg::ACT_POINT, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0, 1, 1),
      mk(fsc_pkg::ACT_POINT, 7, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0, 0, 0, 1, 1),
      mk(fsc_pkg::ACT_SPHERE, 0, 0, 0, 0, 0, 0, 0, 31'h7fffffff, 1, 1),
      mk(fsc_pkg::ACT_BOX, 0, 32'h7fffffff, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
         32'h7fffffff, 0, 1, 1),
      mk(fsc_pkg::ACT_BOX, 0, 0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 0, 1, 1),
      mk(fsc_pkg::ACT_CAPSULE, 0, 0, 0, 0, 0, 32'h80000000, 0, 31'h7fffffff, 1, 1),
      mk(ACT_SPARE6, 0, 0, 0, 0, 0, 0, 0, 0),
      mk(ACT_SPARE7, 7, -1, -1, -1, -1, -1, -1, 31'h7fffffff),
      mk(fsc_pkg::ACT_LOAD_PLANE, 6, ONE, 0, 0, ONE, 0, 0, 0),
      mk(fsc_pkg::ACT_LOAD_PLANE, 7, ONE, 0, 0, ONE, 0, 0, 0),
      mk(fsc_pkg::ACT_LOAD_ROW, 3, ONE, ONE, ONE, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_LOAD_ROW, 7, ONE, ONE, ONE, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_POINT, 0, -ONE, -ONE, -ONE, 0, 0, 0, 0, 1, 1),
      mk(fsc_pkg::ACT_LOAD_PLANE, 0, 0, 0, 0, ONE, 0, 0, 0),
      mk(fsc_pkg::ACT_POINT, 0, -1, 0, 0, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_SPHERE, 0, -ONE, 0, 0, 0, 0, 0, 31'd1),
      mk(fsc_pkg::ACT_LOAD_ROW, 0, ONE, 0, 0, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_LOAD_ROW, 1, 0, ONE, 0, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_LOAD_ROW, 2, 0, 0, ONE, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_BOX, 0, -3 * ONE, 0, 0, 4 * ONE, ONE, ONE, 0),
      mk(fsc_pkg::ACT_CAPSULE, 0, -ONE, 0, 0, 0, ONE, 0, 31'(4 * ONE)),
      mk(fsc_pkg::ACT_LOAD_PLANE, 5, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
         32'h80000000, 32'h80000000, 32'h80000000, 0),
      mk(fsc_pkg::ACT_POINT, 0, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0, 0),
      mk(fsc_pkg::ACT_SPHERE, 0, 32'h80000000, 0, 32'h7fffffff, 0, 0, 0, 31'h7fffffff),
      mk(fsc_pkg::ACT_BOX, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -2, -2, -2, 0)
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_tbl[i]) send_item(directed_tbl[i]);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      calm = (n >= 600 && n < 900);
      send_item(random_item());
    end
    in_ch.valid <= 1'b0;
    calm = 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("PASS frustum_shape_cull");
    end else begin
      $display("FAIL frustum_shape_cull");
    end
    $finish;
  end

endmodule
